// ----- rtl/tia_pkg.sv -----
// ----------------------------------------------------------------------------
// tia_pkg: shared widths and constants of the tap interval averager
// Field widths of the request, response and control channels, and the
// reset value of the gap limit register.
// ----------------------------------------------------------------------------
package tia_pkg;

   localparam int TIME_W    = 32;
   localparam int IVL_W     = 16;
   localparam int SPREAD_W  = 15;
   localparam int SAMPLES_W = 4;

   // longest accepted interval after reset, in milliseconds
   localparam logic [IVL_W-1:0] GAP_LIMIT_RESET = 16'd5000;

endpackage

// ----- rtl/tia_ifs.sv -----
// ----------------------------------------------------------------------------
// tia_ifs: channel interfaces of the tap interval averager
// Tap requests, average responses and the gap limit control write channel,
// each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tia_req_if;
   logic                       valid;
   logic                       ready;
   logic [tia_pkg::TIME_W-1:0] tap_time_ms;

   modport source (output valid, output tap_time_ms, input ready);
   modport sink   (input valid, input tap_time_ms, output ready);
endinterface

interface tia_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tia_pkg::IVL_W-1:0]     average_interval;
   logic [tia_pkg::SPREAD_W-1:0]  spread;
   logic [tia_pkg::SAMPLES_W-1:0] samples_used;

   modport source (output valid, output average_interval, output spread,
                   output samples_used, input ready);
   modport sink   (input valid, input average_interval, input spread,
                   input samples_used, output ready);
endinterface

interface tia_csr_if;
   logic                      valid;
   logic                      ready;
   logic [tia_pkg::IVL_W-1:0] gap_limit_ms;

   modport source (output valid, output gap_limit_ms, input ready);
   modport sink   (input valid, input gap_limit_ms, output ready);
endinterface

// ----- rtl/tia_cell.sv -----
// ----------------------------------------------------------------------------
// tia_cell: one interval cell of the history chain
// Holds one stored interval and takes its neighbor's value on every shift.
// ----------------------------------------------------------------------------
module tia_cell (
   input  logic                      clock,
   input  logic                      shift,
   input  logic [tia_pkg::IVL_W-1:0] value_prev,
   output logic [tia_pkg::IVL_W-1:0] value
);
   import tia_pkg::*;

   logic [IVL_W-1:0] value_ff;
   logic [IVL_W-1:0] value_in;

   // take the neighbor's value on shift, hold otherwise
   always_comb begin
      value_in = value_ff;
      if (shift) begin
         value_in = value_prev;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ----- rtl/tia_divider.sv -----
// ----------------------------------------------------------------------------
// tia_divider: iterative restoring divider
// Produces one quotient bit per cycle, most significant first; the quotient
// is held after done until the next start.
// ----------------------------------------------------------------------------
module tia_divider #(
   parameter int DIVIDEND_W = 20,
   parameter int DIVISOR_W  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);
   import tia_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_sub;
   logic                  fits;

   // trial subtraction of one step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      rem_sub   = rem_shift - {1'b0, div_ff};
      fits      = rem_shift >= {1'b0, div_ff};
   end

   // load on start, advance one bit per cycle while busy
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = LAST_STEP;
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/tap_interval_averager.sv -----
// ----------------------------------------------------------------------------
// tap_interval_averager: tap-tempo moving average of recent tap intervals
//
//   channel  role    carries
//   req_if   sink    tap_time_ms, one item per tap
//   rsp_if   source  average_interval, spread, samples_used
//   csr_if   sink    gap_limit_ms, always ready
//
// An accepted tap inside the gap limit takes one rotation of the interval
// chain to collect sum, min and max, then one quotient bit per cycle in the
// divider. A tap beyond the gap limit restarts the history, leaves the
// averager idle and sends no response for that tap.
// The response sits in an output register; a new tap is accepted while it
// waits, and a finished result holds until the output register frees up.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module tap_interval_averager #(
   parameter int HISTORY_DEPTH = 10
) (
   input  logic clock,
   input  logic reset,
   tia_req_if.sink   req_if,
   tia_rsp_if.source rsp_if,
   tia_csr_if.sink   csr_if
);
   import tia_pkg::*;

   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int STEP_W = $clog2(HISTORY_DEPTH);
   localparam int SUM_W  = IVL_W + CNT_W;
   localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(HISTORY_DEPTH);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(HISTORY_DEPTH - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_LAUNCH = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_HOLD   = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [IVL_W-1:0]    gap_limit_ff, gap_limit_in;
   logic [TIME_W-1:0]   last_time_ff, last_time_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [IVL_W-1:0]    lo_ff, lo_in;
   logic [IVL_W-1:0]    hi_ff, hi_in;
   logic [SPREAD_W-1:0] spread_ff, spread_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IVL_W-1:0]    rsp_avg_ff, rsp_avg_in;
   logic [SPREAD_W-1:0] rsp_spread_ff, rsp_spread_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                req_take;
   logic [TIME_W-1:0]   gap;
   logic                long_gap;
   logic                shift;
   logic                insert;
   logic [IVL_W-1:0]    head_value;
   logic [IVL_W-1:0]    tail;
   logic                tail_live;
   logic [CNT_W-1:0]    skip_steps;
   logic [IVL_W-1:0]    range;
   logic                div_start;
   logic                div_done;
   logic [SUM_W-1:0]    div_quotient;
   logic                out_free;
   logic [CNT_W+SAMPLES_W-1:0] samples_ext;

   logic [IVL_W-1:0] cell_value [HISTORY_DEPTH];

   // accept taps only between items; control writes always
   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_take     = req_if.valid && req_if.ready;

   // interval since the previous tap, modulo 2^32
   assign gap      = req_if.tap_time_ms - last_time_ff;
   assign long_gap = gap > {{(TIME_W-IVL_W){1'b0}}, gap_limit_ff};

   // chain: insert the new interval at the head, or rotate tail to head
   assign insert     = req_take && !long_gap;
   assign shift      = insert || (state_ff == S_SCAN);
   assign head_value = insert ? gap[IVL_W-1:0] : cell_value[HISTORY_DEPTH-1];
   assign tail       = cell_value[HISTORY_DEPTH-1];

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         tia_cell u_cell (
            .clock      (clock),
            .shift      (shift),
            .value_prev (head_value),
            .value      (cell_value[i])
         );
      end else begin : g_body
         tia_cell u_cell (
            .clock      (clock),
            .shift      (shift),
            .value_prev (cell_value[i-1]),
            .value      (cell_value[i])
         );
      end
   end

   // only the newest count_ff cells hold live intervals
   assign skip_steps = DEPTH_C - count_ff;
   assign tail_live  = CNT_W'(step_ff) >= skip_steps;
   assign range      = hi_ff - lo_ff;

   assign div_start = (state_ff == S_LAUNCH);
   assign out_free  = !rsp_valid_ff || rsp_if.ready;

   tia_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // sequence one tap through scan, divide and output
   always_comb begin
      state_in      = state_ff;
      gap_limit_in  = gap_limit_ff;
      last_time_in  = last_time_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      sum_in        = sum_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      spread_in     = spread_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_avg_in    = rsp_avg_ff;
      rsp_spread_in = rsp_spread_ff;
      rsp_count_in  = rsp_count_ff;

      if (csr_if.valid && csr_if.ready) begin
         gap_limit_in = csr_if.gap_limit_ms;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               last_time_in = req_if.tap_time_ms;
               if (long_gap) begin
                  count_in = '0;
               end else begin
                  count_in = (count_ff == DEPTH_C) ? DEPTH_C : count_ff + 1'b1;
                  step_in  = '0;
                  sum_in   = '0;
                  lo_in    = '1;
                  hi_in    = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (tail_live) begin
               sum_in = sum_ff + {{CNT_W{1'b0}}, tail};
               if (tail < lo_ff) begin
                  lo_in = tail;
               end
               if (tail > hi_ff) begin
                  hi_in = tail;
               end
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = S_LAUNCH;
            end
         end
         S_LAUNCH: begin
            spread_in = range[IVL_W-1:1];
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_avg_in    = div_quotient[IVL_W-1:0];
               rsp_spread_in = spread_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gap_limit_ff <= GAP_LIMIT_RESET;
         last_time_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gap_limit_ff <= gap_limit_in;
         last_time_ff <= last_time_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff       <= step_in;
      sum_ff        <= sum_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      spread_ff     <= spread_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_spread_ff <= rsp_spread_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // report the count in its low four bits
   assign samples_ext = {{SAMPLES_W{1'b0}}, rsp_count_ff};

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.average_interval = rsp_avg_ff;
   assign rsp_if.spread           = rsp_spread_ff;
   assign rsp_if.samples_used     = samples_ext[SAMPLES_W-1:0];

endmodule
